// ----- rtl/pipe_byte_fifo_with_endpoints_assert.svh -----
// ---------------------------------------------------------------------------
// Pipe byte FIFO assertion macros
// Clocked, reset-qualified property helpers for the pipe byte FIFO.
// ---------------------------------------------------------------------------
`ifndef PIPE_BYTE_FIFO_WITH_ENDPOINTS_ASSERT_SVH
`define PIPE_BYTE_FIFO_WITH_ENDPOINTS_ASSERT_SVH

// Same-cycle implication.
`define PBF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbf assertion failed");

// Next-cycle implication.
`define PBF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbf assertion failed");

`endif

// ----- rtl/pbf_pkg.sv -----
// ---------------------------------------------------------------------------
// Pipe byte FIFO package
// Sizes, request and status codes shared by the pipe byte FIFO files.
// ---------------------------------------------------------------------------
package pbf_pkg;

    localparam int DEPTH    = 4096;
    localparam int MAX_REFS = 255;

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int REFS_W  = $clog2(MAX_REFS + 1);
    localparam int FILL_W  = 13;
    localparam int DATA_W  = 8;
    localparam int REQ_W   = 3;
    localparam int STAT_W  = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE   = 3'd0,
        REQ_READ    = 3'd1,
        REQ_ADD_RD  = 3'd2,
        REQ_ADD_WR  = 3'd3,
        REQ_DROP_RD = 3'd4,
        REQ_DROP_WR = 3'd5,
        REQ_CREATE  = 3'd6
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_EOF      = 3'd2,
        ST_BROKEN   = 3'd3,
        ST_FULL     = 3'd4,
        ST_NOT_OPEN = 3'd5
    } status_t;

    typedef struct packed {
        logic              rd_hit;
        logic [STAT_W-1:0] status;
        logic [FILL_W-1:0] fill_level;
        logic              released;
    } pend_t;

endpackage

// ----- rtl/pbf_req_if.sv -----
// ---------------------------------------------------------------------------
// Pipe byte FIFO request channel
// Valid/ready channel carrying one request beat.
// ---------------------------------------------------------------------------
interface pbf_req_if;
    logic                       valid;
    logic                       ready;
    logic [pbf_pkg::REQ_W-1:0]  req_type;
    logic [pbf_pkg::DATA_W-1:0] wr_data;

    modport source (output valid, output req_type, output wr_data, input ready);
    modport sink   (input valid, input req_type, input wr_data, output ready);
endinterface

// ----- rtl/pbf_rsp_if.sv -----
// ---------------------------------------------------------------------------
// Pipe byte FIFO response channel
// Valid/ready channel carrying one result beat.
// ---------------------------------------------------------------------------
interface pbf_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [pbf_pkg::DATA_W-1:0] rd_data;
    logic [pbf_pkg::STAT_W-1:0] status;
    logic [pbf_pkg::FILL_W-1:0] fill_level;
    logic                       released;

    modport source (output valid, output rd_data, output status, output fill_level,
                    output released, input ready);
    modport sink   (input valid, input rd_data, input status, input fill_level,
                    input released, output ready);
endinterface

// ----- rtl/pbf_ram.sv -----
// ---------------------------------------------------------------------------
// Pipe byte FIFO RAM
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module pbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/pipe_byte_fifo_with_endpoints.sv -----
// ---------------------------------------------------------------------------
// Pipe byte FIFO with endpoints
// Circular byte FIFO with reader and writer endpoint counts.
//
// Requests arrive on req (req_type, wr_data); one result beat per request
// leaves on rsp (rd_data, status, fill_level, released), in request order.
// Control state (indices, fill count, endpoint counts, open flag) sits in
// flops and is updated at the edge that accepts the request; the bytes
// sit in a RAM with one write and one registered read port.
// A result beat passes through the pending stage and then the output
// register; the RAM read starts at the accepting edge and its data is
// registered into the output when the pending beat advances.
// Throughput: one request per cycle while rsp is not stalled; each
// request makes at most one RAM access.
// Stall: a pending stage and an output register decouple the sides; req
// keeps accepting while one result waits and drops ready only when both
// hold a beat and rsp is stalled.
// Reset: the pipe is closed with all counts zero; the RAM is not cleared
// and needs no clearing pass, so requests are taken right after reset.
// ---------------------------------------------------------------------------
`include "pipe_byte_fifo_with_endpoints_assert.svh"

module pipe_byte_fifo_with_endpoints (
    input  logic      clk,
    input  logic      rst_n,
    pbf_req_if.sink   req,
    pbf_rsp_if.source rsp
);

    logic [pbf_pkg::ADDR_W-1:0]  widx_reg, widx_next;
    logic [pbf_pkg::ADDR_W-1:0]  ridx_reg, ridx_next;
    logic [pbf_pkg::COUNT_W-1:0] held_count_reg, held_count_next;
    logic [pbf_pkg::REFS_W-1:0]  rd_refs_reg, rd_refs_next;
    logic [pbf_pkg::REFS_W-1:0]  wr_refs_reg, wr_refs_next;
    logic                        open_reg, open_next;

    logic                        s1_valid_reg;
    pbf_pkg::pend_t              s1_reg, s1_next;
    logic                        out_valid_reg;
    logic [pbf_pkg::DATA_W-1:0]  out_data_reg;
    pbf_pkg::pend_t              out_reg;

    logic                        accept;
    logic                        s1_adv;
    logic                        ram_we;
    logic                        ram_re;
    logic [pbf_pkg::DATA_W-1:0]  ram_rdata;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_adv;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        widx_next       = widx_reg;
        ridx_next       = ridx_reg;
        held_count_next = held_count_reg;
        rd_refs_next    = rd_refs_reg;
        wr_refs_next    = wr_refs_reg;
        open_next       = open_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        s1_next.rd_hit   = 1'b0;
        s1_next.status   = pbf_pkg::ST_OK;
        s1_next.released = 1'b0;

        if (req.req_type == pbf_pkg::REQ_CREATE)
        begin
            widx_next       = '0;
            ridx_next       = '0;
            held_count_next = '0;
            rd_refs_next    = pbf_pkg::REFS_W'(1);
            wr_refs_next    = pbf_pkg::REFS_W'(1);
            open_next       = 1'b1;
        end
        else if (!open_reg)
        begin
            s1_next.status = pbf_pkg::ST_NOT_OPEN;
        end
        else
        begin
            case (req.req_type)
                pbf_pkg::REQ_WRITE:
                begin
                    if (rd_refs_reg == '0)
                    begin
                        s1_next.status = pbf_pkg::ST_BROKEN;
                    end
                    else if (held_count_reg == pbf_pkg::COUNT_W'(pbf_pkg::DEPTH))
                    begin
                        s1_next.status = pbf_pkg::ST_FULL;
                    end
                    else
                    begin
                        ram_we          = accept;
                        widx_next       = (widx_reg == pbf_pkg::ADDR_W'(pbf_pkg::DEPTH - 1))
                                          ? '0 : widx_reg + 1'b1;
                        held_count_next = held_count_reg + 1'b1;
                    end
                end
                pbf_pkg::REQ_READ:
                begin
                    if (held_count_reg != '0)
                    begin
                        ram_re          = accept;
                        s1_next.rd_hit  = 1'b1;
                        ridx_next       = (ridx_reg == pbf_pkg::ADDR_W'(pbf_pkg::DEPTH - 1))
                                          ? '0 : ridx_reg + 1'b1;
                        held_count_next = held_count_reg - 1'b1;
                    end
                    else if (wr_refs_reg == '0)
                    begin
                        s1_next.status = pbf_pkg::ST_EOF;
                    end
                    else
                    begin
                        s1_next.status = pbf_pkg::ST_EMPTY;
                    end
                end
                pbf_pkg::REQ_ADD_RD:
                begin
                    if (rd_refs_reg != pbf_pkg::REFS_W'(pbf_pkg::MAX_REFS))
                    begin
                        rd_refs_next = rd_refs_reg + 1'b1;
                    end
                end
                pbf_pkg::REQ_ADD_WR:
                begin
                    if (wr_refs_reg != pbf_pkg::REFS_W'(pbf_pkg::MAX_REFS))
                    begin
                        wr_refs_next = wr_refs_reg + 1'b1;
                    end
                end
                pbf_pkg::REQ_DROP_RD, pbf_pkg::REQ_DROP_WR:
                begin
                    if (req.req_type == pbf_pkg::REQ_DROP_RD && rd_refs_reg != '0)
                    begin
                        rd_refs_next = rd_refs_reg - 1'b1;
                    end
                    if (req.req_type == pbf_pkg::REQ_DROP_WR && wr_refs_reg != '0)
                    begin
                        wr_refs_next = wr_refs_reg - 1'b1;
                    end
                    if (rd_refs_next == '0 && wr_refs_next == '0)
                    begin
                        open_next        = 1'b0;
                        widx_next        = '0;
                        ridx_next        = '0;
                        held_count_next  = '0;
                        s1_next.released = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        s1_next.fill_level = open_next ? pbf_pkg::FILL_W'(held_count_next) : '0;
    end

    pbf_ram #(
        .WIDTH (pbf_pkg::DATA_W),
        .DEPTH (pbf_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (widx_reg),
        .wdata (req.wr_data),
        .re    (ram_re),
        .raddr (ridx_reg),
        .rdata (ram_rdata)
    );

    // Control state and handshake flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            widx_reg       <= '0;
            ridx_reg       <= '0;
            held_count_reg <= '0;
            rd_refs_reg    <= '0;
            wr_refs_reg    <= '0;
            open_reg       <= 1'b0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                widx_reg       <= widx_next;
                ridx_reg       <= ridx_next;
                held_count_reg <= held_count_next;
                rd_refs_reg    <= rd_refs_next;
                wr_refs_reg    <= wr_refs_next;
                open_reg       <= open_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: advance the pending beat, hold it while stalled.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_adv)
        begin
            out_reg      <= s1_reg;
            out_data_reg <= s1_reg.rd_hit ? ram_rdata : '0;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.rd_data    = out_data_reg;
    assign rsp.status     = out_reg.status;
    assign rsp.fill_level = out_reg.fill_level;
    assign rsp.released   = out_reg.released;

    `PBF_ASSERT_NOW(a_held_bound, 1'b1,
                    held_count_reg <= pbf_pkg::COUNT_W'(pbf_pkg::DEPTH))
    `PBF_ASSERT_NOW(a_closed_empty, !open_reg,
                    held_count_reg == '0 && rd_refs_reg == '0 && wr_refs_reg == '0)
    `PBF_ASSERT_NEXT(a_stall_hold, s1_valid_reg && out_valid_reg && !rsp.ready,
                     s1_valid_reg && out_valid_reg)
    `PBF_ASSERT_NEXT(a_read_pending, accept && ram_re, s1_valid_reg && s1_reg.rd_hit)

endmodule
